// File: rtl/core/scr_pkg.sv
`default_nettype none

package scr_pkg;

    // Pair selector codes
    typedef enum logic [2:0] {
        REQ_RECT_POINT    = 3'd0,
        REQ_RECT_RECT     = 3'd1,
        REQ_RECT_CIRCLE   = 3'd2,
        REQ_CIRCLE_POINT  = 3'd3,
        REQ_CIRCLE_RECT   = 3'd4,
        REQ_CIRCLE_CIRCLE = 3'd5
    } scr_req_t;

    // Classification handed from front to back
    typedef struct packed {
        logic hit;
        logic scale;   // push needs sqrt and divide
        logic neg;     // negate the final push
    } scr_ctrl_t;

    // Decoupling queue size
    localparam int SCR_QAW    = 2;
    localparam int SCR_QDEPTH = 1 << SCR_QAW;

endpackage

`default_nettype wire

// File: rtl/core/shape_collision_resolve_2d.sv
`default_nettype none

// Channel   Handshake              Fields
// request   push / full            req_type, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
// result    empty / pop            hit, push_x, push_y
//
// One request per cycle sustained while results are popped without stalls. A request
// passes 3 front stages, then the queue, then 2*COORD_BITS+4 back stages (square root
// and two dividers, one bit per stage each).
// Reset clears all valid flags and the queue; no memory sweep.
// A stalled result freezes the back pipeline; the front keeps taking requests
// until the 4-entry queue is full and its last stage holds a request, then raises full.

module shape_collision_resolve_2d #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   req_type,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-2:0]        a_w,
    input  logic [COORD_BITS-2:0]        a_h,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic [COORD_BITS-2:0]        b_w,
    input  logic [COORD_BITS-2:0]        b_h,
    output logic                         empty,
    input  logic                         pop,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] push_x,
    output logic signed [COORD_BITS-1:0] push_y
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 2;
    localparam int QW = $bits(scr_pkg::scr_ctrl_t) + 4*DW + 2*CW + CW;

    scr_pkg::scr_ctrl_t   f_ctrl, b_ctrl;
    logic signed [DW-1:0] f_dpx, f_dpy, f_dx, f_dy;
    logic signed [DW-1:0] b_dpx, b_dpy, b_dx, b_dy;
    logic [2*CW-1:0]      f_d2, b_d2;
    logic [CW-1:0]        f_rad, b_rad;
    logic                 q_wr, q_full, q_empty, q_rd, b_ready;
    logic [QW-1:0]        q_wdata, q_rdata;

    scr_front #(.CW(CW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_w      (a_w),
        .a_h      (a_h),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_w      (b_w),
        .b_h      (b_h),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .ctrl     (f_ctrl),
        .dpx      (f_dpx),
        .dpy      (f_dpy),
        .dx       (f_dx),
        .dy       (f_dy),
        .d2       (f_d2),
        .rad      (f_rad)
    );

    assign q_wdata = {f_ctrl, f_dpx, f_dpy, f_dx, f_dy, f_d2, f_rad};
    assign q_rd    = !q_empty && b_ready;

    scr_queue #(.W(QW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_ctrl, b_dpx, b_dpy, b_dx, b_dy, b_d2, b_rad} = q_rdata;

    scr_back #(.CW(CW)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (!q_empty),
        .ready  (b_ready),
        .ctrl   (b_ctrl),
        .dpx    (b_dpx),
        .dpy    (b_dpy),
        .dx     (b_dx),
        .dy     (b_dy),
        .d2     (b_d2),
        .rad    (b_rad),
        .pop    (pop),
        .empty  (empty),
        .hit    (hit),
        .push_x (push_x),
        .push_y (push_y)
    );

endmodule

`default_nettype wire

// File: rtl/core/scr_front.sv
`default_nettype none

module scr_front #(
    parameter int CW = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [2:0]              req_type,
    input  logic signed [CW-1:0]    a_x,
    input  logic signed [CW-1:0]    a_y,
    input  logic [CW-2:0]           a_w,
    input  logic [CW-2:0]           a_h,
    input  logic signed [CW-1:0]    b_x,
    input  logic signed [CW-1:0]    b_y,
    input  logic [CW-2:0]           b_w,
    input  logic [CW-2:0]           b_h,
    input  logic                    q_full,
    output logic                    q_wr,
    output scr_pkg::scr_ctrl_t      ctrl,
    output logic signed [CW+1:0]    dpx,
    output logic signed [CW+1:0]    dpy,
    output logic signed [CW+1:0]    dx,
    output logic signed [CW+1:0]    dy,
    output logic [2*CW-1:0]         d2,
    output logic [CW-1:0]           rad
);

    localparam int DW = CW + 2;
    localparam int MW = CW + 1;

    logic en;

    // stage 1: captured request
    logic                   s1_v_reg;
    scr_pkg::scr_req_t      s1_type_reg;
    logic signed [CW-1:0]   s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic [CW-2:0]          s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;

    // stage 2: differences and edge distances
    logic                   s2_v_reg;
    scr_pkg::scr_req_t      s2_type_reg;
    logic                   s2_hs_reg, s2_strict_reg, s2_neg_reg;
    logic signed [DW-1:0]   s2_q1_reg, s2_q2_reg, s2_q3_reg, s2_q4_reg;
    logic signed [DW-1:0]   s2_dx_reg, s2_dy_reg;
    logic [CW-1:0]          s2_r_reg;

    // stage 3: squares and direct pushes
    logic                   s3_v_reg;
    scr_pkg::scr_req_t      s3_type_reg;
    logic                   s3_hs_reg, s3_strict_reg, s3_neg_reg;
    logic signed [DW-1:0]   s3_dpx_reg, s3_dpy_reg, s3_dx_reg, s3_dy_reg;
    logic [CW-1:0]          s3_r_reg;
    logic [2*MW-1:0]        s3_sqx_reg, s3_sqy_reg;
    logic [2*CW-1:0]        s3_sqr_reg;

    assign en   = !(s3_v_reg && q_full);
    assign full = !en;
    assign q_wr = s3_v_reg && !q_full;

    // ---------------- stage 1 logic ----------------
    logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [DW-1:0] rx, ry, rw, rh, cx, cy, cr, rxe, rye, kx, ky;
    logic signed [DW-1:0] rr_l, rr_r, rr_t, rr_b, rs;
    logic                 is_rc, sw, pt_hit, rr_hit, rr_strict;
    logic signed [DW-1:0] s1_q1, s1_q2, s1_q3, s1_q4, s1_dx, s1_dy, s1_r;

    assign ax = {{2{s1_ax_reg[CW-1]}}, s1_ax_reg};
    assign ay = {{2{s1_ay_reg[CW-1]}}, s1_ay_reg};
    assign bx = {{2{s1_bx_reg[CW-1]}}, s1_bx_reg};
    assign by = {{2{s1_by_reg[CW-1]}}, s1_by_reg};
    assign aw = {3'b000, s1_aw_reg};
    assign ah = {3'b000, s1_ah_reg};
    assign bw = {3'b000, s1_bw_reg};
    assign bh = {3'b000, s1_bh_reg};

    assign pt_hit = (bx >= ax) && (bx <= ax + aw) && (by >= ay) && (by <= ay + ah);
    assign rr_hit = (ax <= bx + bw) && (ax + aw >= bx) && (ay <= by + bh) && (ay + ah >= by);
    assign rr_strict = !((ax >= bx + bw) || (ax + aw <= bx) ||
                         (ay >= by + bh) || (ay + ah <= by));
    assign rr_l = bx + bw - ax;
    assign rr_r = ax + aw - bx;
    assign rr_t = by + bh - ay;
    assign rr_b = ay + ah - by;
    assign rs   = aw + bw;

    // circle-rect swaps roles: rectangle from B, circle from A
    assign sw    = (s1_type_reg == scr_pkg::REQ_CIRCLE_RECT);
    assign is_rc = sw || (s1_type_reg == scr_pkg::REQ_RECT_CIRCLE);
    assign rx  = sw ? bx : ax;
    assign ry  = sw ? by : ay;
    assign rw  = sw ? bw : aw;
    assign rh  = sw ? bh : ah;
    assign cx  = sw ? ax : bx;
    assign cy  = sw ? ay : by;
    assign cr  = sw ? aw : bw;
    assign rxe = rx + rw;
    assign rye = ry + rh;
    assign kx  = (cx < rx) ? rx : ((cx > rxe) ? rxe : cx);
    assign ky  = (cy < ry) ? ry : ((cy > rye) ? rye : cy);

    always_comb
    begin
        if (is_rc)
        begin
            s1_dx = kx - cx;
            s1_dy = ky - cy;
            s1_r  = cr;
            s1_q1 = cx - rx;
            s1_q2 = rxe - cx;
            s1_q3 = cy - ry;
            s1_q4 = rye - cy;
        end
        else
        begin
            s1_dx = ax - bx;
            s1_dy = ay - by;
            s1_r  = (s1_type_reg == scr_pkg::REQ_CIRCLE_CIRCLE) ? rs : aw;
            s1_q1 = rr_l;
            s1_q2 = rr_r;
            s1_q3 = rr_t;
            s1_q4 = rr_b;
        end
    end

    // ---------------- stage 2 logic ----------------
    logic signed [DW-1:0] ndx, ndy, r_s, mx, my, s2_px, s2_py;
    logic [MW-1:0]        magx, magy;
    logic                 lx, ly;

    assign ndx  = -s2_dx_reg;
    assign ndy  = -s2_dy_reg;
    assign magx = s2_dx_reg[DW-1] ? ndx[MW-1:0] : s2_dx_reg[MW-1:0];
    assign magy = s2_dy_reg[DW-1] ? ndy[MW-1:0] : s2_dy_reg[MW-1:0];
    assign r_s  = {2'b00, s2_r_reg};
    assign lx   = s2_q1_reg < s2_q2_reg;
    assign ly   = s2_q3_reg < s2_q4_reg;
    assign mx   = lx ? s2_q1_reg : s2_q2_reg;
    assign my   = ly ? s2_q3_reg : s2_q4_reg;

    // smaller axis wins, a tie goes to y
    always_comb
    begin
        s2_px = '0;
        s2_py = '0;
        if (s2_type_reg == scr_pkg::REQ_RECT_RECT)
        begin
            if (mx < my)
                s2_px = lx ? -s2_q1_reg : s2_q2_reg;
            else
                s2_py = ly ? -s2_q3_reg : s2_q4_reg;
        end
        else
        begin
            if (mx < my)
                s2_px = lx ? (r_s - s2_q1_reg) : -(r_s - s2_q2_reg);
            else
                s2_py = ly ? -(r_s - s2_q3_reg) : (r_s - s2_q4_reg);
        end
    end

    // ---------------- stage 3 logic ----------------
    logic [2*MW:0] d2_full;
    logic          lt, le, zero;

    assign d2_full = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
    assign le      = d2_full <= {3'b000, s3_sqr_reg};
    assign lt      = d2_full <  {3'b000, s3_sqr_reg};
    assign zero    = (s3_dx_reg == '0) && (s3_dy_reg == '0);

    always_comb
    begin
        ctrl.hit   = 1'b0;
        ctrl.scale = 1'b0;
        ctrl.neg   = s3_neg_reg;
        dpx        = '0;
        dpy        = '0;
        unique case (s3_type_reg)
            scr_pkg::REQ_RECT_POINT:
                ctrl.hit = s3_hs_reg;
            scr_pkg::REQ_RECT_RECT:
            begin
                ctrl.hit = s3_hs_reg;
                if (s3_strict_reg)
                begin
                    dpx = s3_dpx_reg;
                    dpy = s3_dpy_reg;
                end
            end
            scr_pkg::REQ_RECT_CIRCLE, scr_pkg::REQ_CIRCLE_RECT:
            begin
                ctrl.hit = le;
                if (lt && zero)
                begin
                    dpx = s3_dpx_reg;
                    dpy = s3_dpy_reg;
                end
                else if (lt)
                    ctrl.scale = 1'b1;
            end
            scr_pkg::REQ_CIRCLE_POINT:
                ctrl.hit = le;
            scr_pkg::REQ_CIRCLE_CIRCLE:
            begin
                ctrl.hit = le;
                if (lt && zero)
                    dpx = {2'b00, s3_r_reg};
                else if (lt)
                    ctrl.scale = 1'b1;
            end
            default:
                ctrl.hit = 1'b0;
        endcase
    end

    assign dx  = s3_dx_reg;
    assign dy  = s3_dy_reg;
    assign d2  = d2_full[2*CW-1:0];
    assign rad = s3_r_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= push;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_type_reg   <= scr_pkg::scr_req_t'(req_type);
            s1_ax_reg     <= a_x;
            s1_ay_reg     <= a_y;
            s1_aw_reg     <= a_w;
            s1_ah_reg     <= a_h;
            s1_bx_reg     <= b_x;
            s1_by_reg     <= b_y;
            s1_bw_reg     <= b_w;
            s1_bh_reg     <= b_h;

            s2_type_reg   <= s1_type_reg;
            s2_hs_reg     <= (s1_type_reg == scr_pkg::REQ_RECT_POINT) ? pt_hit : rr_hit;
            s2_strict_reg <= rr_strict;
            s2_neg_reg    <= sw;
            s2_q1_reg     <= s1_q1;
            s2_q2_reg     <= s1_q2;
            s2_q3_reg     <= s1_q3;
            s2_q4_reg     <= s1_q4;
            s2_dx_reg     <= s1_dx;
            s2_dy_reg     <= s1_dy;
            s2_r_reg      <= s1_r[CW-1:0];

            s3_type_reg   <= s2_type_reg;
            s3_hs_reg     <= s2_hs_reg;
            s3_strict_reg <= s2_strict_reg;
            s3_neg_reg    <= s2_neg_reg;
            s3_dpx_reg    <= s2_px;
            s3_dpy_reg    <= s2_py;
            s3_dx_reg     <= s2_dx_reg;
            s3_dy_reg     <= s2_dy_reg;
            s3_r_reg      <= s2_r_reg;
            s3_sqx_reg    <= magx * magx;
            s3_sqy_reg    <= magy * magy;
            s3_sqr_reg    <= s2_r_reg * s2_r_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scr_queue.sv
`default_nettype none

module scr_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int AW = scr_pkg::SCR_QAW;
    localparam int D  = scr_pkg::SCR_QDEPTH;

    logic [W-1:0]  mem_reg [0:D-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = cnt_reg == (AW+1)'(D);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(D))
        else $error("queue count beyond depth");

    a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("request written into full queue");

    a_no_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && empty))
        else $error("request read from empty queue");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a write");

endmodule

`default_nettype wire

// File: rtl/core/scr_back.sv
`default_nettype none

module scr_back #(
    parameter int CW = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    output logic                    ready,
    input  scr_pkg::scr_ctrl_t      ctrl,
    input  logic signed [CW+1:0]    dpx,
    input  logic signed [CW+1:0]    dpy,
    input  logic signed [CW+1:0]    dx,
    input  logic signed [CW+1:0]    dy,
    input  logic [2*CW-1:0]         d2,
    input  logic [CW-1:0]           rad,
    input  logic                    pop,
    output logic                    empty,
    output logic                    hit,
    output logic signed [CW-1:0]    push_x,
    output logic signed [CW-1:0]    push_y
);

    localparam int DW   = CW + 2;
    localparam int LAST = 2*CW + 3;    // output register
    localparam int PEN  = CW + 1;      // pen stage index
    localparam logic signed [DW-1:0] SMAX = {{3{1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {{3{1'b1}}, {(CW-1){1'b0}}};

    logic en;

    logic                 v_reg      [0:LAST];
    scr_pkg::scr_ctrl_t   c_ctrl_reg [0:LAST-1];
    logic signed [DW-1:0] c_px_reg   [0:LAST-1];
    logic signed [DW-1:0] c_py_reg   [0:LAST-1];
    logic signed [DW-1:0] c_dx_reg   [0:LAST-1];
    logic signed [DW-1:0] c_dy_reg   [0:LAST-1];
    logic [CW-1:0]        c_rad_reg  [0:CW];

    // square root, two radicand bits a stage
    logic [CW+1:0]   sq_rem_reg  [0:CW];
    logic [CW-1:0]   sq_root_reg [0:CW];
    logic [2*CW-1:0] sq_rad_reg  [0:CW];
    logic [CW+1:0]   sq_remn     [0:CW-1];
    logic [CW+1:0]   sq_trial    [0:CW-1];
    logic            sq_ge       [0:CW-1];

    logic [CW-1:0]   pen_reg, den_reg;

    // two restoring dividers, one quotient bit a stage
    logic [CW:0]     dvx_rem_reg [0:CW];
    logic [CW:0]     dvy_rem_reg [0:CW];
    logic [CW-1:0]   dvx_n_reg   [0:CW];
    logic [CW-1:0]   dvy_n_reg   [0:CW];
    logic [CW-1:0]   dvx_q_reg   [0:CW];
    logic [CW-1:0]   dvy_q_reg   [0:CW];
    logic [CW-1:0]   dv_den_reg  [0:CW];
    logic [CW:0]     dvx_remn    [0:CW-1];
    logic [CW:0]     dvy_remn    [0:CW-1];
    logic            dvx_ge      [0:CW-1];
    logic            dvy_ge      [0:CW-1];

    logic            hit_reg;
    logic signed [CW-1:0] push_x_reg, push_y_reg;
    logic signed [CW-1:0] push_x_next, push_y_next;

    assign en     = !(v_reg[LAST] && !pop);
    assign ready  = en;
    assign empty  = !v_reg[LAST];
    assign hit    = hit_reg;
    assign push_x = push_x_reg;
    assign push_y = push_y_reg;

    always_comb
    begin
        for (int k = 0; k < CW; k++)
        begin
            sq_remn[k]  = {sq_rem_reg[k][CW-1:0], sq_rad_reg[k][2*CW-1 -: 2]};
            sq_trial[k] = {sq_root_reg[k], 2'b01};
            sq_ge[k]    = sq_remn[k] >= sq_trial[k];
            dvx_remn[k] = {dvx_rem_reg[k][CW-1:0], dvx_n_reg[k][CW-1]};
            dvy_remn[k] = {dvy_rem_reg[k][CW-1:0], dvy_n_reg[k][CW-1]};
            dvx_ge[k]   = dvx_remn[k] >= {1'b0, dv_den_reg[k]};
            dvy_ge[k]   = dvy_remn[k] >= {1'b0, dv_den_reg[k]};
        end
    end

    // |d| fits CW bits whenever a scaled push is taken
    logic signed [DW-1:0] ndx, ndy;
    logic [CW-1:0]        magx, magy;
    logic [2*CW-1:0]      prodx, prody;

    assign ndx   = -c_dx_reg[PEN];
    assign ndy   = -c_dy_reg[PEN];
    assign magx  = c_dx_reg[PEN][DW-1] ? ndx[CW-1:0] : c_dx_reg[PEN][CW-1:0];
    assign magy  = c_dy_reg[PEN][DW-1] ? ndy[CW-1:0] : c_dy_reg[PEN][CW-1:0];
    assign prodx = magx * pen_reg;
    assign prody = magy * pen_reg;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        t = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return t[CW-1:0];
    endfunction

    // sign, select and saturate
    scr_pkg::scr_ctrl_t   fc;
    logic signed [DW-1:0] qx, qy, sx, sy, vx, vy;

    assign fc = c_ctrl_reg[LAST-1];
    assign qx = {2'b00, dvx_q_reg[CW]};
    assign qy = {2'b00, dvy_q_reg[CW]};

    always_comb
    begin
        sx = c_dx_reg[LAST-1][DW-1] ? -qx : qx;
        sy = c_dy_reg[LAST-1][DW-1] ? -qy : qy;
        vx = fc.scale ? sx : c_px_reg[LAST-1];
        vy = fc.scale ? sy : c_py_reg[LAST-1];
        if (fc.neg)
        begin
            vx = -vx;
            vy = -vy;
        end
        push_x_next = sat_c(vx);
        push_y_next = sat_c(vy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= take;
            for (int k = 1; k <= LAST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ctrl_reg[0] <= ctrl;
            c_px_reg[0]   <= dpx;
            c_py_reg[0]   <= dpy;
            c_dx_reg[0]   <= dx;
            c_dy_reg[0]   <= dy;
            c_rad_reg[0]  <= rad;
            for (int k = 1; k < LAST; k++)
            begin
                c_ctrl_reg[k] <= c_ctrl_reg[k-1];
                c_px_reg[k]   <= c_px_reg[k-1];
                c_py_reg[k]   <= c_py_reg[k-1];
                c_dx_reg[k]   <= c_dx_reg[k-1];
                c_dy_reg[k]   <= c_dy_reg[k-1];
            end
            for (int k = 1; k <= CW; k++)
                c_rad_reg[k] <= c_rad_reg[k-1];

            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= d2;
            for (int k = 0; k < CW; k++)
            begin
                sq_rem_reg[k+1]  <= sq_ge[k] ? sq_remn[k] - sq_trial[k] : sq_remn[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][CW-2:0], sq_ge[k]};
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][2*CW-3:0], 2'b00};
            end

            pen_reg <= c_rad_reg[CW] - sq_root_reg[CW];
            den_reg <= sq_root_reg[CW];

            dvx_rem_reg[0] <= {1'b0, prodx[2*CW-1:CW]};
            dvy_rem_reg[0] <= {1'b0, prody[2*CW-1:CW]};
            dvx_n_reg[0]   <= prodx[CW-1:0];
            dvy_n_reg[0]   <= prody[CW-1:0];
            dvx_q_reg[0]   <= '0;
            dvy_q_reg[0]   <= '0;
            dv_den_reg[0]  <= den_reg;
            for (int k = 0; k < CW; k++)
            begin
                dvx_rem_reg[k+1] <= dvx_ge[k] ? dvx_remn[k] - {1'b0, dv_den_reg[k]}
                                              : dvx_remn[k];
                dvy_rem_reg[k+1] <= dvy_ge[k] ? dvy_remn[k] - {1'b0, dv_den_reg[k]}
                                              : dvy_remn[k];
                dvx_n_reg[k+1]   <= {dvx_n_reg[k][CW-2:0], 1'b0};
                dvy_n_reg[k+1]   <= {dvy_n_reg[k][CW-2:0], 1'b0};
                dvx_q_reg[k+1]   <= {dvx_q_reg[k][CW-2:0], dvx_ge[k]};
                dvy_q_reg[k+1]   <= {dvy_q_reg[k][CW-2:0], dvy_ge[k]};
                dv_den_reg[k+1]  <= dv_den_reg[k];
            end

            hit_reg    <= fc.hit;
            push_x_reg <= push_x_next;
            push_y_reg <= push_y_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CB = 24;
    localparam int WB = CB - 1;
    localparam int N_RANDOM = 1950;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic                 hit;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } contact_t;

    // Collision predictor and store of pending contact results
    class contact_board;
        contact_t pending[$];
        int errors;

        // squared distances stay below 2^52, so the root fits 32 bits
        function longint sq_root(longint unsigned v);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        // d*pen/dlen truncated toward zero
        function longint scale_push(longint d, longint pen, longint dlen);
            longint unsigned q;
            longint unsigned m;
            m = (d < 0) ? -d : d;
            q = (m * pen) / dlen;
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function bit rect_vs_circle(longint rx, longint ry, longint rw, longint rh,
                                    longint cx, longint cy, longint r,
                                    output longint px, output longint py);
            longint dx, dy, d2, r2, l, rt, t, bt, dlen, pen;
            bit h;
            dx = clip(cx, rx, rx + rw) - cx;
            dy = clip(cy, ry, ry + rh) - cy;
            d2 = dx * dx + dy * dy;
            r2 = r * r;
            h = d2 <= r2;
            px = 0;
            py = 0;
            if (r2 > d2)
            begin
                if (dx == 0 && dy == 0)
                begin
                    l = cx - rx; rt = rx + rw - cx;
                    t = cy - ry; bt = ry + rh - cy;
                    if ((l < rt ? l : rt) < (t < bt ? t : bt))
                        px = l < rt ? r - l : -(r - rt);
                    else
                        py = t < bt ? -(r - t) : r - bt;
                end
                else
                begin
                    dlen = sq_root(d2);
                    pen = r - dlen;
                    px = scale_push(dx, pen, dlen);
                    py = scale_push(dy, pen, dlen);
                end
            end
            return h;
        endfunction

        function logic signed [CB-1:0] sat(longint v);
            return CB'(clip(v, -(64'sd1 << (CB-1)), (64'sd1 << (CB-1)) - 1));
        endfunction

        function void note_request(logic [2:0] kind, longint ax, longint ay, longint aw,
                                   longint ah, longint bx, longint by, longint bw,
                                   longint bh);
            longint px, py, dx, dy, l, r, t, b, rs, d2, dlen;
            bit h;
            contact_t e;
            px = 0; py = 0; h = 0;
            case (kind)
                scr_pkg::REQ_RECT_POINT:
                    h = bx >= ax && bx <= ax + aw && by >= ay && by <= ay + ah;
                scr_pkg::REQ_RECT_RECT:
                begin
                    h = ax <= bx + bw && ax + aw >= bx && ay <= by + bh && ay + ah >= by;
                    if (!(ax >= bx + bw || ax + aw <= bx || ay >= by + bh || ay + ah <= by))
                    begin
                        l = bx + bw - ax; r = ax + aw - bx;
                        t = by + bh - ay; b = ay + ah - by;
                        if ((l < r ? l : r) < (t < b ? t : b)) px = l < r ? -l : r;
                        else py = t < b ? -t : b;
                    end
                end
                scr_pkg::REQ_RECT_CIRCLE:
                    h = rect_vs_circle(ax, ay, aw, ah, bx, by, bw, px, py);
                scr_pkg::REQ_CIRCLE_POINT:
                    h = (ax - bx) * (ax - bx) + (ay - by) * (ay - by) <= aw * aw;
                scr_pkg::REQ_CIRCLE_RECT:
                begin
                    h = rect_vs_circle(bx, by, bw, bh, ax, ay, aw, px, py);
                    px = -px;
                    py = -py;
                end
                scr_pkg::REQ_CIRCLE_CIRCLE:
                begin
                    dx = ax - bx; dy = ay - by; rs = aw + bw;
                    d2 = dx * dx + dy * dy;
                    h = d2 <= rs * rs;
                    if (rs * rs > d2)
                    begin
                        if (dx == 0 && dy == 0) px = rs;
                        else
                        begin
                            dlen = sq_root(d2);
                            px = scale_push(dx, rs - dlen, dlen);
                            py = scale_push(dy, rs - dlen, dlen);
                        end
                    end
                end
                default: ;
            endcase
            e.hit = h;
            e.px = sat(px);
            e.py = sat(py);
            pending.push_back(e);
        endfunction

        function void check_result(logic h, logic signed [CB-1:0] px,
                                   logic signed [CB-1:0] py);
            contact_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b push=(%0d,%0d)", $time, h, px, py);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (h !== e.hit)
            begin
                $display("%0t: hit expected %0b actual %0b", $time, e.hit, h);
                errors++;
            end
            if (px !== e.px)
            begin
                $display("%0t: push_x expected %0d actual %0d", $time, e.px, px);
                errors++;
            end
            if (py !== e.py)
            begin
                $display("%0t: push_y expected %0d actual %0d", $time, e.py, py);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic [2:0] req_type = '0;
    logic signed [CB-1:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
    logic [WB-1:0] a_w = '0, a_h = '0, b_w = '0, b_h = '0;
    logic full, empty, hit;
    logic signed [CB-1:0] push_x, push_y;

    contact_board board = new();
    bit calm = 0;
    bit stim_done = 0;
    int cycles = 0;

    shape_collision_resolve_2d #(.COORD_BITS(CB)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check on accept, pop stalls in bursts
    initial
    begin
        int gap;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) board.check_result(hit, push_x, push_y);
            if (gap > 0)
            begin
                gap--;
                pop <= 0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 10) - 1;
                pop <= 0;
            end
            else
                pop <= 1;
        end
    end

    function automatic logic signed [CB-1:0] rand_coord(int spread);
        case ($urandom_range(0, 9))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom);
            default: return CB'(int'($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic logic [WB-1:0] rand_size(int spread);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WB'($urandom);
            default: return WB'($urandom_range(0, spread));
        endcase
    endfunction

    task automatic send(logic [2:0] k, logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
                        logic [WB-1:0] aw, logic [WB-1:0] ah, logic signed [CB-1:0] bx,
                        logic signed [CB-1:0] by, logic [WB-1:0] bw, logic [WB-1:0] bh);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        req_type <= k;
        a_x <= ax; a_y <= ay; a_w <= aw; a_h <= ah;
        b_x <= bx; b_y <= by; b_w <= bw; b_h <= bh;
        do @(posedge clk); while (full);
        board.note_request(k, ax, ay, aw, ah, bx, by, bw, bh);
    endtask

    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [WB-1:0] SMAX = '1;

    initial
    begin
        int spread;
        logic [2:0] k;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, each pair kind, edge and inside cases
        send(scr_pkg::REQ_RECT_POINT, 0, 0, 100, 100, 100, 100, 0, 0);
        send(scr_pkg::REQ_RECT_POINT, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, 0, 0);
        send(scr_pkg::REQ_RECT_RECT, 0, 0, 100, 100, 100, 50, 50, 50);
        send(scr_pkg::REQ_RECT_RECT, 0, 0, 100, 100, 90, 20, 50, 50);
        send(scr_pkg::REQ_RECT_RECT, 0, 0, 100, 100, 20, 90, 50, 50);
        send(scr_pkg::REQ_RECT_RECT, 0, 0, 100, 100, 20, -40, 50, 50);
        send(scr_pkg::REQ_RECT_RECT, 10, 10, 20, 20, 0, 0, 40, 40);
        send(scr_pkg::REQ_RECT_RECT, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 150, 50, 50, 0);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 130, 130, 50, 0);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 10, 50, 30, 0);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 90, 50, 30, 0);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 50, 10, 30, 0);
        send(scr_pkg::REQ_RECT_CIRCLE, 0, 0, 100, 100, 50, 95, 30, 0);
        send(scr_pkg::REQ_CIRCLE_POINT, 0, 0, 50, 0, 30, 40, 0, 0);
        send(scr_pkg::REQ_CIRCLE_POINT, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX);
        send(scr_pkg::REQ_CIRCLE_RECT, 150, 50, 60, 0, 0, 0, 100, 100);
        send(scr_pkg::REQ_CIRCLE_RECT, 50, 95, 30, 0, 0, 0, 100, 100);
        send(scr_pkg::REQ_CIRCLE_CIRCLE, 0, 0, 30, 0, 50, 0, 20, 0);
        send(scr_pkg::REQ_CIRCLE_CIRCLE, 0, 0, 30, 0, 40, 30, 30, 0);
        send(scr_pkg::REQ_CIRCLE_CIRCLE, 7, 7, 10, 0, 7, 7, 5, 0);
        send(scr_pkg::REQ_CIRCLE_CIRCLE, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX);
        send(scr_pkg::REQ_CIRCLE_CIRCLE, 0, 0, SMAX, 0, 0, 0, SMAX, 0);
        send(3'd6, 1, 1, 1, 1, 1, 1, 1, 1);
        send(3'd7, CMAX, CMIN, SMAX, SMAX, CMIN, CMAX, SMAX, SMAX);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i > N_RANDOM * 9 / 10) calm = 1;
            // mostly close-range pairs so that overlaps are common
            spread = ($urandom_range(0, 3) == 0) ? 1 << $urandom_range(8, 22) :
                     1 << $urandom_range(2, 12);
            k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
                3'($urandom_range(0, 5));
            send(k, rand_coord(spread), rand_coord(spread), rand_size(spread),
                 rand_size(spread), rand_coord(spread), rand_coord(spread),
                 rand_size(spread), rand_size(spread));
        end
        push <= 0;
        wait (board.pending.size() == 0);
        repeat (2 * CB + 20) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
rtl/core/scr_pkg.sv
rtl/core/scr_front.sv
rtl/core/scr_queue.sv
rtl/core/scr_back.sv
rtl/core/shape_collision_resolve_2d.sv
dv/tb.sv
